>>> design/arpc_pkg.sv
package arpc_pkg;

	// ARP header field values
	localparam logic [15:0] HW_ETHERNET   = 16'h0001;
	localparam logic [15:0] PROTO_IPV4    = 16'h0800;
	localparam logic [7:0]  MAX_HW_LEN    = 8'd6;
	localparam logic [7:0]  MAX_PROTO_LEN = 8'd4;
	localparam logic [15:0] OP_REQUEST    = 16'h0001;
	localparam logic [15:0] OP_REPLY      = 16'h0002;

	// Result status codes
	localparam logic [2:0] ST_BAD_HEADER  = 3'd0;
	localparam logic [2:0] ST_BAD_OP      = 3'd1;
	localparam logic [2:0] ST_REQ_OTHER   = 3'd2;
	localparam logic [2:0] ST_REPLY_SENT  = 3'd3;
	localparam logic [2:0] ST_REPLY_OTHER = 3'd4;
	localparam logic [2:0] ST_REFRESHED   = 3'd5;
	localparam logic [2:0] ST_INSERTED    = 3'd6;
	localparam logic [2:0] ST_FULL        = 3'd7;

	// Configuration register indexes
	localparam int          CFG_IDX_W   = 1;
	localparam int          CFG_DATA_W  = 48;
	localparam logic [0:0]  CFG_OWN_MAC = 1'b0;
	localparam logic [0:0]  CFG_OWN_IP  = 1'b1;

	typedef struct packed {
		logic [15:0] hw_type;
		logic [15:0] proto_type;
		logic [7:0]  hw_addr_len;
		logic [7:0]  proto_addr_len;
		logic [15:0] op_code;
		logic [47:0] sender_mac;
		logic [31:0] sender_ip;
		logic [47:0] target_mac;
		logic [31:0] target_ip;
		logic [31:0] now;
	} in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [47:0] reply_to_mac;
		logic [31:0] reply_to_ip;
		logic [3:0]  entry_index;
	} out_t;

	typedef struct packed {
		logic [31:0] ip;
		logic [47:0] mac;
		logic [31:0] tstamp;
	} cache_entry_t;

	// Controller to datapath
	typedef struct packed {
		logic latch_in;
		logic set_fast;
		logic clr_idx;
		logic rd_en;
		logic commit;
		logic load_out;
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic need_scan;
		logic last_idx;
	} dp_stat_t;

endpackage

>>> design/arpc_ctrl.sv
module arpc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	output logic                  out_valid,
	input  logic                  out_stall,
	input  arpc_pkg::dp_stat_t    stat,
	output arpc_pkg::ctrl_cmd_t   cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_DRAIN  = 3'd3;
	localparam logic [2:0] S_COMMIT = 3'd4;
	localparam logic [2:0] S_DONE   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					state_d      = S_DECODE;
				end
			end
			S_DECODE: begin
				if (stat.need_scan) begin
					cmd.clr_idx = 1'b1;
					state_d     = S_SCAN;
				end else begin
					cmd.set_fast = 1'b1;
					state_d      = S_DONE;
				end
			end
			S_SCAN: begin
				cmd.rd_en = 1'b1;
				if (stat.last_idx)
					state_d = S_DRAIN;
			end
			S_DRAIN: begin
				state_d = S_COMMIT;
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	a_accept_decodes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && in_valid && !in_stall) |=> state_q == S_DECODE)
		else $error("accepted transfer did not enter decode");

	a_scan_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && stat.last_idx) |=> state_q == S_DRAIN)
		else $error("scan did not stop at the last entry");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load_out && out_valid_q && out_stall))
		else $error("output register overwritten while stalled");

endmodule

>>> design/arpc_dp.sv
module arpc_dp #(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_wr_en,
	input  logic [arpc_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [arpc_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  arpc_pkg::in_t                          in_data,
	output arpc_pkg::out_t                         out_data,
	input  arpc_pkg::ctrl_cmd_t                    cmd,
	output arpc_pkg::dp_stat_t                     stat
);

	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

	logic [47:0]            own_mac_q;
	logic [31:0]            own_ip_q;
	arpc_pkg::in_t          item_q;
	arpc_pkg::out_t         res_q;
	arpc_pkg::out_t         out_q;
	arpc_pkg::out_t         fast_res;
	arpc_pkg::out_t         commit_res;
	arpc_pkg::cache_entry_t mem_q [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] valid_q;

	logic [IW-1:0]          idx_q;
	logic                   rd_en_s1;
	logic [IW-1:0]          idx_s1;
	arpc_pkg::cache_entry_t rd_data_s1;
	logic                   rd_vld_s1;

	logic                   found_match_q;
	logic [IW-1:0]          match_idx_q;
	logic                   found_free_q;
	logic [IW-1:0]          free_idx_q;

	logic                   hdr_ok;
	arpc_pkg::cache_entry_t eff_entry;
	logic                   hit;
	logic                   free;
	logic                   wr_en;
	logic [IW-1:0]          wr_idx;
	logic [31:0]            wr_idx_wide;

	// Header checks and the outcomes that need no cache access
	always_comb begin
		hdr_ok = (item_q.hw_type == arpc_pkg::HW_ETHERNET) &&
			(item_q.proto_type == arpc_pkg::PROTO_IPV4) &&
			(item_q.hw_addr_len <= arpc_pkg::MAX_HW_LEN) &&
			(item_q.proto_addr_len <= arpc_pkg::MAX_PROTO_LEN);
		fast_res        = '0;
		fast_res.status = arpc_pkg::ST_BAD_HEADER;
		stat.need_scan  = 1'b0;
		stat.last_idx   = (idx_q == LAST_IDX);
		if (hdr_ok) begin
			if (item_q.op_code == arpc_pkg::OP_REQUEST) begin
				if (item_q.target_ip == own_ip_q) begin
					fast_res.status       = arpc_pkg::ST_REPLY_SENT;
					fast_res.reply_to_mac = item_q.sender_mac;
					fast_res.reply_to_ip  = item_q.sender_ip;
				end else begin
					fast_res.status = arpc_pkg::ST_REQ_OTHER;
				end
			end else if (item_q.op_code == arpc_pkg::OP_REPLY) begin
				if (item_q.target_mac == own_mac_q)
					stat.need_scan = 1'b1;
				else
					fast_res.status = arpc_pkg::ST_REPLY_OTHER;
			end else begin
				fast_res.status = arpc_pkg::ST_BAD_OP;
			end
		end
	end

	// Entries never written read as all zero
	assign eff_entry = rd_vld_s1 ? rd_data_s1 : '0;
	assign hit  = (eff_entry.ip == item_q.sender_ip) && (eff_entry.mac == item_q.sender_mac);
	assign free = (eff_entry.ip == 32'd0) && (eff_entry.tstamp == 32'd0);

	assign wr_en       = cmd.commit && (found_match_q || found_free_q);
	assign wr_idx      = found_match_q ? match_idx_q : free_idx_q;
	assign wr_idx_wide = 32'(wr_idx);

	// Outcome of a cache sweep
	always_comb begin
		commit_res = '0;
		if (found_match_q) begin
			commit_res.status      = arpc_pkg::ST_REFRESHED;
			commit_res.entry_index = wr_idx_wide[3:0];
		end else if (found_free_q) begin
			commit_res.status      = arpc_pkg::ST_INSERTED;
			commit_res.entry_index = wr_idx_wide[3:0];
		end else begin
			commit_res.status = arpc_pkg::ST_FULL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_mac_q     <= '0;
			own_ip_q      <= '0;
			valid_q       <= '0;
			idx_q         <= '0;
			rd_en_s1      <= 1'b0;
			found_match_q <= 1'b0;
			found_free_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					arpc_pkg::CFG_OWN_MAC: own_mac_q <= cfg_data[47:0];
					arpc_pkg::CFG_OWN_IP:  own_ip_q  <= cfg_data[31:0];
					default: ;
				endcase
			end
			rd_en_s1 <= cmd.rd_en;
			if (cmd.clr_idx) begin
				idx_q         <= '0;
				found_match_q <= 1'b0;
				found_free_q  <= 1'b0;
			end else begin
				if (cmd.rd_en)
					idx_q <= idx_q + 1'b1;
				if (rd_en_s1) begin
					if (hit && !found_match_q)
						found_match_q <= 1'b1;
					if (free && !found_free_q)
						found_free_q <= 1'b1;
				end
			end
			if (wr_en)
				valid_q[wr_idx] <= 1'b1;
		end
	end

	// Cache memory: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_idx] <= '{ip: item_q.sender_ip, mac: item_q.sender_mac,
				tstamp: item_q.now};
		if (cmd.rd_en) begin
			rd_data_s1 <= mem_q[idx_q];
			rd_vld_s1  <= valid_q[idx_q];
			idx_s1     <= idx_q;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.latch_in)
			item_q <= in_data;
		if (rd_en_s1 && !cmd.clr_idx) begin
			if (hit && !found_match_q)
				match_idx_q <= idx_s1;
			if (free && !found_free_q)
				free_idx_q <= idx_s1;
		end
		if (cmd.set_fast)
			res_q <= fast_res;
		else if (cmd.commit)
			res_q <= commit_res;
		if (cmd.load_out)
			out_q <= res_q;
	end

	assign out_data = out_q;

	a_refresh_status: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && found_match_q) |=> res_q.status == arpc_pkg::ST_REFRESHED)
		else $error("matching entry not reported as refreshed");

	a_write_marks_valid: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> valid_q[$past(wr_idx)])
		else $error("written entry not marked valid");

endmodule

>>> design/arp_responder_and_cache_top.sv
// ARP responder and cache. Each transfer on the input channel carries one parsed ARP
// header in host order plus the current time; each yields exactly one result transfer.
// Headers that are not Ethernet/IPv4 with address lengths of at most 6 and 4 bytes give
// status 0. A request for own_ip gives status 3 with the sender's addresses to reply to.
// A reply to own_mac scans the cache: the lowest entry with equal IP and MAC has its
// timestamp refreshed (status 5), otherwise the lowest free entry (IP and time both zero)
// is filled (status 6), otherwise status 7. An item that needs no cache access skips the
// sweep; a reply to own_mac waits on the single read port of the cache memory, which is
// swept one entry a cycle. One item is worked on at a time; the next is taken while a
// finished result still waits in the output register. The cache reads as all zero after
// reset through one valid bit per entry, so no clearing pass is needed. Write own_mac
// (index 0) and own_ip (index 1) only while the block is idle.
module arp_responder_and_cache_top #(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [arpc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [arpc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  arpc_pkg::in_t                    in_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output arpc_pkg::out_t                   out_data
);

	arpc_pkg::ctrl_cmd_t cmd;
	arpc_pkg::dp_stat_t  stat;

	// Sequence decode, cache sweep, commit and output transfer
	arpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Hold the item, the own addresses and the cache; compare and update entries
	arpc_dp #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.out_data  (out_data),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

>>> test/arpc_result_checker.sv
module arpc_result_checker #(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [arpc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [arpc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  arpc_pkg::in_t                   in_data,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  arpc_pkg::out_t                  out_data,
	output int                              mismatches,
	output int                              pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import arpc_pkg::*;

	logic [47:0] own_mac;
	logic [31:0] own_ip;
	logic [31:0] peer_ip    [TABLE_ENTRIES];
	logic [47:0] peer_mac   [TABLE_ENTRIES];
	logic [31:0] peer_stamp [TABLE_ENTRIES];
	out_t        replies_due[$];

	// Work out the result of one header and update the cache copy.
	function automatic out_t resolve_arp(input in_t hdr);
		out_t res;
		int   i;
		int   hit;
		int   slot;
		res  = '0;
		hit  = -1;
		slot = -1;
		if (hdr.hw_type != HW_ETHERNET || hdr.proto_type != PROTO_IPV4 ||
				hdr.hw_addr_len > MAX_HW_LEN || hdr.proto_addr_len > MAX_PROTO_LEN) begin
			res.status = ST_BAD_HEADER;
		end else if (hdr.op_code == OP_REQUEST) begin
			if (hdr.target_ip != own_ip) begin
				res.status = ST_REQ_OTHER;
			end else begin
				res.status       = ST_REPLY_SENT;
				res.reply_to_mac = hdr.sender_mac;
				res.reply_to_ip  = hdr.sender_ip;
			end
		end else if (hdr.op_code != OP_REPLY) begin
			res.status = ST_BAD_OP;
		end else if (hdr.target_mac != own_mac) begin
			res.status = ST_REPLY_OTHER;
		end else begin
			for (i = 0; i < TABLE_ENTRIES; i++) begin
				if (hit < 0 && peer_ip[i] == hdr.sender_ip && peer_mac[i] == hdr.sender_mac)
					hit = i;
				if (slot < 0 && peer_ip[i] == '0 && peer_stamp[i] == '0)
					slot = i;
			end
			if (hit >= 0) begin
				peer_stamp[hit] = hdr.now;
				res.status      = ST_REFRESHED;
				res.entry_index = hit[3:0];
			end else if (slot >= 0) begin
				peer_ip[slot]    = hdr.sender_ip;
				peer_mac[slot]   = hdr.sender_mac;
				peer_stamp[slot] = hdr.now;
				res.status       = ST_INSERTED;
				res.entry_index  = slot[3:0];
			end else begin
				res.status = ST_FULL;
			end
		end
		return res;
	endfunction

	task automatic check_result(input out_t got);
		out_t want;
		if (replies_due.size() == 0) begin
			$error("result transfer with no header outstanding (status %0d)", got.status);
			mismatches++;
			return;
		end
		want = replies_due.pop_front();
		if (got.status !== want.status) begin
			$error("status: expected %0d, got %0d", want.status, got.status);
			mismatches++;
		end
		if (got.reply_to_mac !== want.reply_to_mac) begin
			$error("reply_to_mac: expected %h, got %h", want.reply_to_mac, got.reply_to_mac);
			mismatches++;
		end
		if (got.reply_to_ip !== want.reply_to_ip) begin
			$error("reply_to_ip: expected %h, got %h", want.reply_to_ip, got.reply_to_ip);
			mismatches++;
		end
		if (got.entry_index !== want.entry_index) begin
			$error("entry_index: expected %0d, got %0d", want.entry_index, got.entry_index);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_mac = '0;
			own_ip  = '0;
			foreach (peer_ip[i]) begin
				peer_ip[i]    = '0;
				peer_mac[i]   = '0;
				peer_stamp[i] = '0;
			end
			replies_due.delete();
			mismatches = 0;
		end else begin
			if (cfg_wr_en) begin
				if (cfg_index == CFG_OWN_MAC)
					own_mac = cfg_data[47:0];
				else if (cfg_index == CFG_OWN_IP)
					own_ip = cfg_data[31:0];
			end
			if (out_valid && !out_stall)
				check_result(out_data);
			if (in_valid && !in_stall)
				replies_due.push_back(resolve_arp(in_data));
		end
		pending = replies_due.size();
	end

endmodule

>>> test/arp_responder_and_cache_top_tb.sv
module arp_responder_and_cache_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import arpc_pkg::*;

	localparam int POOL_SIZE     = 20;
	localparam int PHASE_ITEMS   = 482;
	localparam int DRAIN_CYCLES  = 30;

	// Receiver behaviour: each mode lasts a random span of cycles.
	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_LONG} stall_mode_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	in_t                   in_data;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_t                  out_data;
	int                    mismatches;
	int                    pending;

	// Stimulus-side copy of the configured addresses, used to aim headers at us.
	logic [47:0] cur_mac;
	logic [31:0] cur_ip;

	// Known peers: replies drawn from here produce refreshes as well as inserts.
	logic [31:0] pool_ip  [POOL_SIZE];
	logic [47:0] pool_mac [POOL_SIZE];

	int burst_left;

	stall_mode_t stall_mode = STALL_NONE;
	int          stall_span = 0;
	int          stall_run  = 0;

	arp_responder_and_cache_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	arpc_result_checker result_watch (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver stall pattern, changed at the falling edge only. Modes cover no
	// back-pressure at all, sparse and dense random stalls, and long holds broken
	// by short releases.
	always @(negedge clk) begin
		if (stall_span == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			stall_span = $urandom_range(20, 200);
		end else begin
			stall_span--;
		end
		case (stall_mode)
			STALL_NONE: out_stall = 1'b0;
			STALL_LIGHT: out_stall = ($urandom_range(0, 3) == 0);
			STALL_HEAVY: out_stall = ($urandom_range(0, 3) != 0);
			default: begin
				if (stall_run == 0) begin
					stall_run = out_stall ? $urandom_range(1, 6) : $urandom_range(1, 40);
					out_stall = !out_stall;
				end else begin
					stall_run--;
				end
			end
		endcase
	end

	// Write one register; call at a falling edge while the block is idle.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		if (idx == CFG_OWN_MAC)
			cur_mac = val[47:0];
		else
			cur_ip = val[31:0];
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	// Drop valid and hold off until every outstanding result has been transferred.
	// Each header yields exactly one result, so an empty queue means the block is idle.
	task automatic settle();
		in_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	// Present one header and hold it until the transfer; then either carry on
	// with the burst (valid stays high) or drop valid for a random gap.
	task automatic offer(input in_t hdr);
		int gap;
		in_valid = 1'b1;
		in_data  = hdr;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			// Mostly short bursts; now and then a long stretch with no gaps.
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
			if (gap > 0) begin
				in_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	endtask

	// Well-formed Ethernet/IPv4 header at the maximum address lengths.
	function automatic in_t arp_hdr(input logic [15:0] op, input logic [47:0] smac,
			input logic [31:0] sip, input logic [47:0] tmac, input logic [31:0] tip,
			input logic [31:0] stamp);
		in_t h;
		h.hw_type        = HW_ETHERNET;
		h.proto_type     = PROTO_IPV4;
		h.hw_addr_len    = MAX_HW_LEN;
		h.proto_addr_len = MAX_PROTO_LEN;
		h.op_code        = op;
		h.sender_mac     = smac;
		h.sender_ip      = sip;
		h.target_mac     = tmac;
		h.target_ip      = tip;
		h.now            = stamp;
		return h;
	endfunction

	// Random header: mostly well-formed requests and replies aimed at us from the
	// peer pool, the rest raw noise, broken headers and bad opcodes.
	function automatic in_t pick_header();
		in_t h;
		int  roll;
		int  who;
		h = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		roll = $urandom_range(0, 99);
		if (roll < 10)
			return h;
		h.hw_type        = HW_ETHERNET;
		h.proto_type     = PROTO_IPV4;
		h.hw_addr_len    = 8'($urandom_range(0, MAX_HW_LEN));
		h.proto_addr_len = 8'($urandom_range(0, MAX_PROTO_LEN));
		if (roll < 20) begin
			// Break exactly one header check.
			case ($urandom_range(0, 3))
				0: h.hw_type = HW_ETHERNET ^ 16'($urandom_range(1, 16'hFFFF));
				1: h.proto_type = PROTO_IPV4 ^ 16'($urandom_range(1, 16'hFFFF));
				2: h.hw_addr_len = 8'($urandom_range(MAX_HW_LEN + 1, 255));
				default: h.proto_addr_len = 8'($urandom_range(MAX_PROTO_LEN + 1, 255));
			endcase
			return h;
		end
		if (roll < 25) begin
			h.op_code = ($urandom_range(0, 7) == 0) ? 16'h0000 :
				16'($urandom_range(OP_REPLY + 1, 16'hFFFF));
			return h;
		end
		who          = $urandom_range(0, POOL_SIZE - 1);
		h.sender_ip  = pool_ip[who];
		h.sender_mac = pool_mac[who];
		if (roll < 45) begin
			h.op_code = OP_REQUEST;
			if ($urandom_range(0, 9) < 6)
				h.target_ip = cur_ip;
			return h;
		end
		h.op_code = OP_REPLY;
		if ($urandom_range(0, 19) < 17)
			h.target_mac = cur_mac;
		// Same IP, new MAC: forces an insert beside the existing entry.
		if ($urandom_range(0, 9) == 0)
			h.sender_mac = 48'({$urandom, $urandom});
		// Zero addresses and zero time can match or re-free an entry.
		if ($urandom_range(0, 24) == 0)
			h.sender_ip = '0;
		if ($urandom_range(0, 49) == 0)
			h.sender_mac = '0;
		if ($urandom_range(0, 11) == 0)
			h.now = '0;
		return h;
	endfunction

	// Give up if the run hangs; the slowest legal run is several times shorter.
	initial begin
		#10ms;
		$display("** arp_responder_and_cache_top: FAILED **");
		$finish;
	end

	initial begin
		logic [47:0] mac_a;
		logic [47:0] mac_b;
		logic [31:0] ip_a;
		logic [31:0] ip_b;
		in_t         h;
		int          phase;
		int          n;

		// Drive every input to a known value before reset.
		arst_n     = 1'b0;
		cfg_wr_en  = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		in_valid   = 1'b0;
		in_data    = '0;
		cur_mac    = '0;
		cur_ip     = '0;
		burst_left = 0;
		foreach (pool_ip[i]) begin
			pool_ip[i]  = $urandom;
			pool_mac[i] = 48'({$urandom, $urandom});
		end
		mac_a = 48'h0A1B_2C3D_4E5F;
		mac_b = 48'h7766_5544_3322;
		ip_a  = 32'h0A00_0005;
		ip_b  = 32'hAC10_2001;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part. Upper bits of the address write are junk and must be dropped.
		write_reg(CFG_OWN_MAC, 48'h0200_5E10_2030);
		write_reg(CFG_OWN_IP, {16'hA5A5, 32'hC0A8_0A01});

		// Header checks, each one failing alone.
		h = arp_hdr(OP_REQUEST, mac_a, ip_a, '0, cur_ip, 32'd100);
		h.hw_type = 16'h0000;
		offer(h);
		h.hw_type = 16'hFFFF;
		offer(h);
		h = arp_hdr(OP_REQUEST, mac_a, ip_a, '0, cur_ip, 32'd100);
		h.proto_type = 16'h86DD;
		offer(h);
		h = arp_hdr(OP_REQUEST, mac_a, ip_a, '0, cur_ip, 32'd100);
		h.hw_addr_len = MAX_HW_LEN + 8'd1;
		offer(h);
		h.hw_addr_len = 8'hFF;
		offer(h);
		h = arp_hdr(OP_REQUEST, mac_a, ip_a, '0, cur_ip, 32'd100);
		h.proto_addr_len = MAX_PROTO_LEN + 8'd1;
		offer(h);
		h.proto_addr_len = 8'hFF;
		offer(h);
		// Zero lengths pass; request for us answered, sender fields at both extremes.
		h = arp_hdr(OP_REQUEST, '1, '1, '1, cur_ip, '1);
		h.hw_addr_len    = 8'h00;
		h.proto_addr_len = 8'h00;
		offer(h);
		offer(arp_hdr(OP_REQUEST, '0, '0, '0, cur_ip, '0));
		offer(arp_hdr(OP_REQUEST, mac_a, ip_a, '0, cur_ip ^ 32'd1, 32'd101));
		// Opcodes outside request and reply.
		offer(arp_hdr(16'h0000, mac_a, ip_a, cur_mac, cur_ip, 32'd102));
		offer(arp_hdr(16'hFFFF, mac_a, ip_a, cur_mac, cur_ip, 32'd103));
		offer(arp_hdr(OP_REPLY + 16'd1, mac_a, ip_a, cur_mac, cur_ip, 32'd104));
		// Reply for some other station leaves the cache alone.
		offer(arp_hdr(OP_REPLY, mac_a, ip_a, cur_mac ^ 48'd1, cur_ip, 32'd105));
		// Insert, refresh, then same IP with a new MAC inserts beside it.
		offer(arp_hdr(OP_REPLY, mac_a, ip_a, cur_mac, cur_ip, 32'd200));
		offer(arp_hdr(OP_REPLY, mac_a, ip_a, cur_mac, cur_ip, 32'd300));
		offer(arp_hdr(OP_REPLY, mac_b, ip_a, cur_mac, cur_ip, 32'd301));
		offer(arp_hdr(OP_REPLY, mac_b, ip_b, cur_mac, cur_ip, 32'd302));
		// All-zero sender matches a free entry and refreshes it, leaving it free.
		offer(arp_hdr(OP_REPLY, '0, '0, cur_mac, cur_ip, '0));
		// Insert with IP zero at time zero: the entry stays free ...
		offer(arp_hdr(OP_REPLY, mac_a, '0, cur_mac, cur_ip, '0));
		// ... so the next insert lands on it again, then refreshes it.
		offer(arp_hdr(OP_REPLY, mac_b, '0, cur_mac, cur_ip, 32'd5));
		offer(arp_hdr(OP_REPLY, mac_b, '0, cur_mac, cur_ip, 32'd9));
		offer(arp_hdr(OP_REPLY, '1, '1, cur_mac, cur_ip, '1));

		// Random part, one setting per phase: all ones, all zeros, then random.
		for (phase = 0; phase < 4; phase++) begin
			settle();
			case (phase)
				0: begin
					write_reg(CFG_OWN_MAC, '1);
					write_reg(CFG_OWN_IP, {16'($urandom), 32'hFFFF_FFFF});
				end
				1: begin
					write_reg(CFG_OWN_MAC, '0);
					write_reg(CFG_OWN_IP, '0);
				end
				default: begin
					write_reg(CFG_OWN_MAC, 48'({$urandom, $urandom}));
					write_reg(CFG_OWN_IP, 48'({$urandom, $urandom}));
				end
			endcase
			for (n = 0; n < PHASE_ITEMS; n++) begin
				offer(pick_header());
				// Occasionally hold off until the pipeline has fully drained.
				if ($urandom_range(0, 199) == 0)
					settle();
			end
		end

		// Drain, then give the block its full latency to show any stray result.
		settle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("** arp_responder_and_cache_top: PASSED **");
		end else begin
			$display("** arp_responder_and_cache_top: FAILED **");
		end
		$finish;
	end

endmodule
